// ===== hw/rtl/cauchy_rs_parity_encoder_defines.svh =====
// Assertion macros for the Cauchy RS parity encoder.
`ifndef CAUCHY_RS_PARITY_ENCODER_DEFINES_SVH
`define CAUCHY_RS_PARITY_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled while in reset.
`define CRPE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, disabled while in reset.
`define CRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/crpe_pkg.sv =====
// Types, constants and field arithmetic shared by the encoder modules.
package crpe_pkg;

	localparam int ROWS      = 8;
	localparam int EXP_STEPS = 14;    // square-and-multiply rounds before the final square
	localparam logic [16:0] GF_POLY = 17'h1002B;

	typedef enum logic [1:0] {
		CFG_INFO_COUNT       = 2'd0,
		CFG_REDUNDANCY_COUNT = 2'd1,
		CFG_WORDS_PER_PACKET = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MUL_SQ   = 2'd0,
		MUL_A    = 2'd1,
		MUL_WORD = 2'd2
	} mul_op_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic [7:0]  packet_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0] parity_word;
		logic [2:0]  row_index;
		logic [11:0] word_position;
		logic        last_of_column;
		logic        last_of_packet;
	} out_item_t;

	typedef struct packed {
		logic    accept;
		logic    load_a;
		logic    mul_en;
		mul_op_t mul_op;
		logic    acc_en;
		logic    row_set1;
		logic    row_clr;
		logic    row_inc;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    emit_load;
		logic    close;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic k_gt1;
		logic k_zero;
		logic close_q;
		logic row_more;
		logic cnt_done;
		logic out_free;
		logic a_zero;
	} sts_t;

	// GF(2^16) product: carry-less partial products, then reduction by the field polynomial
	function automatic logic [15:0] gf_mul(input logic [15:0] a, input logic [15:0] b);
		logic [30:0] p;
		p = '0;
		for (int i = 0; i < 16; i++) begin
			if (b[i]) p = p ^ (31'(a) << i);
		end
		for (int i = 30; i >= 16; i--) begin
			if (p[i]) p = p ^ (31'(GF_POLY) << (i - 16));
		end
		return p[15:0];
	endfunction

endpackage

// ===== hw/rtl/crpe_ctrl.sv =====
// Controller state machine for the encoder: sequences accumulate, inversion and emit.
module crpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  crpe_pkg::sts_t sts,
	output crpe_pkg::cmd_t cmd
);
	import crpe_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_ROW   = 8'b0000_0010,
		ST_SQ    = 8'b0000_0100,
		ST_MA    = 8'b0000_1000,
		ST_WMUL  = 8'b0001_0000,
		ST_CHECK = 8'b0010_0000,
		ST_EMIT  = 8'b0100_0000,
		ST_CLOSE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_op = MUL_SQ;
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.in_range) begin
						if (sts.k_gt1) begin
							cmd.row_set1 = 1'b1;
							state_d = ST_ROW;
						end else begin
							state_d = ST_CHECK;
						end
					end
				end
			end
			ST_ROW: begin
				cmd.load_a  = 1'b1;
				cmd.cnt_clr = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_SQ;
				state_d = sts.cnt_done ? ST_WMUL : ST_MA;
			end
			ST_MA: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = MUL_A;
				cmd.cnt_inc = 1'b1;
				state_d = ST_SQ;
			end
			ST_WMUL: begin
				cmd.acc_en  = 1'b1;
				cmd.mul_op  = MUL_WORD;
				cmd.row_inc = 1'b1;
				state_d = sts.row_more ? ST_ROW : ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.close_q) begin
					cmd.row_clr = 1'b1;
					state_d = sts.k_zero ? ST_CLOSE : ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					cmd.row_inc   = 1'b1;
					if (!sts.row_more) state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				cmd.close = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/crpe_dp.sv =====
// Datapath: config registers, row accumulators, shared GF(2^16) multiplier, output register.
module crpe_dp #(
	parameter int MAX_INFO       = 256,
	parameter int MAX_REDUNDANCY = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [12:0]         cfg_data,
	input  crpe_pkg::in_item_t  in,
	output crpe_pkg::out_item_t out,
	output logic                out_valid,
	input  logic                out_stall,
	input  crpe_pkg::cmd_t      cmd,
	output crpe_pkg::sts_t      sts
);
	import crpe_pkg::*;

	localparam logic [31:0] MaxInfo32 = 32'(MAX_INFO);
	localparam int          KMaxInt   = (MAX_REDUNDANCY < ROWS) ? MAX_REDUNDANCY : ROWS;
	localparam logic [3:0]  KMax      = 4'(KMaxInt);

	logic [8:0]  info_q;
	logic [3:0]  red_q;
	logic [12:0] wpp_q;
	logic [8:0]  n_eff;
	logic [3:0]  k_eff;
	logic [12:0] wpp_eff;

	logic [15:0] acc_q [ROWS];
	logic [15:0] word_q;
	logic [7:0]  pidx_q;
	logic        close_q;
	logic [15:0] res_q;
	logic [3:0]  row_q;
	logic [3:0]  cnt_q;
	logic [11:0] col_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic        in_range;
	logic        close_in;
	logic [9:0]  a_sum;
	logic [15:0] a_val;
	logic [15:0] mul_x, mul_y, prod;
	logic        last_p;
	logic        row_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_q <= 9'd4;
			red_q  <= 4'd2;
			wpp_q  <= 13'd512;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INFO_COUNT:       info_q <= cfg_data[8:0];
				CFG_REDUNDANCY_COUNT: red_q  <= cfg_data[3:0];
				CFG_WORDS_PER_PACKET: wpp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_eff   = ({23'd0, info_q} > MaxInfo32) ? MaxInfo32[8:0] : info_q;
	assign k_eff   = (red_q > KMax) ? KMax : red_q;
	assign wpp_eff = (wpp_q == 13'd0) ? 13'd1 : ((wpp_q > 13'd4096) ? 13'd4096 : wpp_q);

	assign in_range = {1'b0, in.packet_index} < n_eff;
	assign close_in = {1'b0, in.packet_index} == (n_eff - 9'd1);

	// Cauchy element (n + r - 1) xor packet; never zero for an in-range packet
	assign a_sum = {1'b0, n_eff} + {6'd0, row_q} - 10'd1;
	assign a_val = {6'd0, a_sum ^ {2'd0, pidx_q}};

	always_comb begin
		unique case (cmd.mul_op)
			MUL_SQ:   begin mul_x = res_q;  mul_y = res_q; end
			MUL_A:    begin mul_x = res_q;  mul_y = a_val; end
			MUL_WORD: begin mul_x = word_q; mul_y = res_q; end
			default:  begin mul_x = res_q;  mul_y = res_q; end
		endcase
	end
	assign prod = gf_mul(mul_x, mul_y);

	assign last_p   = ({1'b0, col_q} + 13'd1) >= wpp_eff;
	assign row_more = ({1'b0, row_q} + 5'd1) < {1'b0, k_eff};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			word_q  <= in.data_word;
			pidx_q  <= in.packet_index;
			close_q <= close_in;
		end
		if (cmd.load_a) res_q <= a_val;
		else if (cmd.mul_en) res_q <= prod;
		if (cmd.cnt_clr) cnt_q <= '0;
		else if (cmd.cnt_inc) cnt_q <= cnt_q + 4'd1;
		if (cmd.emit_load) begin
			out_q.parity_word    <= acc_q[row_q[2:0]];
			out_q.row_index      <= row_q[2:0];
			out_q.word_position  <= col_q;
			out_q.last_of_column <= !row_more;
			out_q.last_of_packet <= last_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) acc_q[i] <= '0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.close) begin
				for (int i = 0; i < ROWS; i++) acc_q[i] <= '0;
				col_q <= last_p ? 12'd0 : col_q + 12'd1;
			end else if (cmd.accept && in_range && k_eff != 4'd0) begin
				acc_q[0] <= acc_q[0] ^ in.data_word;
			end else if (cmd.acc_en) begin
				acc_q[row_q[2:0]] <= acc_q[row_q[2:0]] ^ prod;
			end
			if (cmd.row_set1) row_q <= 4'd1;
			else if (cmd.row_clr) row_q <= 4'd0;
			else if (cmd.row_inc) row_q <= row_q + 4'd1;
			if (cmd.emit_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out       = out_q;
	assign out_valid = out_valid_q;

	assign sts.in_range = in_range;
	assign sts.k_gt1    = k_eff > 4'd1;
	assign sts.k_zero   = k_eff == 4'd0;
	assign sts.close_q  = close_q;
	assign sts.row_more = row_more;
	assign sts.cnt_done = cnt_q == 4'(EXP_STEPS);
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.a_zero   = a_val == 16'd0;

endmodule

// ===== hw/rtl/cauchy_rs_parity_encoder.sv =====
// Cauchy Reed-Solomon parity encoder over GF(2^16), top level.
// Input channel (in_valid/in_stall/in): one data word and its packet index per transfer,
// words in column order. Output channel (out_valid/out_stall/out): parity words, one
// per redundancy row, rows 0..k-1, with row, word position and last flags.
// Config port (cfg_we/cfg_index/cfg_data): 0 info_count, 1 redundancy_count,
// 2 words_per_packet; write only while the block is idle.
// The input stalls until a word is done. Each row above row 0 needs a field inverse,
// a square-and-multiply chain on the single shared multiplier (1 load, 15 squares,
// 14 multiplies, 1 word multiply); row 0 is a plain XOR. A word that closes a column
// then emits one parity word per row. Out-of-range packet indexes are accepted and
// give no result.
// The output register lets the next word be accepted while the last parity word
// of a column still waits; while out_stall holds a pending word, emission holds at that row.
// Reset restores info_count 4, redundancy_count 2, words_per_packet 512, clears
// accumulators and the word position; no clearing pass is needed.
module cauchy_rs_parity_encoder #(
	parameter int MAX_INFO       = 256,
	parameter int MAX_REDUNDANCY = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [12:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  crpe_pkg::in_item_t  in,
	output logic                out_valid,
	input  logic                out_stall,
	output crpe_pkg::out_item_t out
);
	import crpe_pkg::*;

`include "cauchy_rs_parity_encoder_defines.svh"

	cmd_t cmd;
	sts_t sts;
	logic in_xfer;

	crpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	crpe_dp #(
		.MAX_INFO       (MAX_INFO),
		.MAX_REDUNDANCY (MAX_REDUNDANCY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in        (in),
		.out       (out),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign in_xfer = in_valid && !in_stall;

	`CRPE_ASSERT_SAME(a_inv_nonzero, cmd.load_a, !sts.a_zero, "zero Cauchy element")
	`CRPE_ASSERT_SAME(a_no_overwrite, cmd.emit_load, sts.out_free, "pending result overwritten")
	`CRPE_ASSERT_NEXT(a_no_early_emit, in_xfer, !cmd.emit_load && !cmd.close, "emit right after transfer")

endmodule

// ===== test/cauchy_rs_parity_encoder_tb.sv =====
// Testbench for the Cauchy RS parity encoder: directed and random columns against a predictor.
`timescale 1ns / 100ps

module cauchy_rs_parity_encoder_tb;
	import crpe_pkg::*;

	localparam int SETTLE_CYCLES = 300;   // longer than one item at eight rows
	localparam int WATCHDOG_MAX  = 6000;

	class parity_scoreboard;
		int unsigned info_cnt;
		int unsigned red_cnt;
		int unsigned wpp;
		logic [15:0] acc [ROWS];
		int unsigned col_pos;
		out_item_t   parity_q[$];
		int unsigned errors;

		function void clear_state();
			info_cnt = 4;
			red_cnt  = 2;
			wpp      = 512;
			foreach (acc[i]) acc[i] = '0;
			col_pos  = 0;
			errors   = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [12:0] value);
			case (idx)
				CFG_INFO_COUNT:       info_cnt = value[8:0];
				CFG_REDUNDANCY_COUNT: red_cnt  = value[3:0];
				CFG_WORDS_PER_PACKET: wpp      = value;
				default: ;
			endcase
		endfunction

		function logic [15:0] field_mul(logic [15:0] a, logic [15:0] b);
			logic [16:0] r;
			r = '0;
			for (int i = 15; i >= 0; i--) begin
				r = r << 1;
				if (r[16]) r = {1'b0, r[15:0]} ^ 17'h0002B;
				if (b[i]) r = r ^ {1'b0, a};
			end
			return r[15:0];
		endfunction

		// a^(2^16-2) is the field inverse; zero maps to zero
		function logic [15:0] field_inv(logic [15:0] a);
			logic [15:0] res;
			logic [15:0] base;
			int unsigned e;
			res  = 16'd1;
			base = a;
			e    = 32'hFFFE;
			if (a == 0) return '0;
			while (e != 0) begin
				if (e[0]) res = field_mul(res, base);
				base = field_mul(base, base);
				e = e >> 1;
			end
			return res;
		endfunction

		function void note_input(in_item_t item);
			int unsigned n;
			int unsigned k;
			int unsigned w;
			bit last_p;
			out_item_t res;
			n = (info_cnt > 256) ? 256 : info_cnt;
			k = (red_cnt > ROWS) ? ROWS : red_cnt;
			w = (wpp == 0) ? 1 : ((wpp > 4096) ? 4096 : wpp);
			if (item.packet_index >= n) return;
			for (int r = 0; r < k; r++) begin
				if (r == 0) acc[0] ^= item.data_word;
				else acc[r] ^= field_mul(item.data_word,
					field_inv(16'((n + r - 1) ^ item.packet_index)));
			end
			if (item.packet_index == n - 1) begin
				last_p = (col_pos + 1 >= w);
				for (int r = 0; r < k; r++) begin
					res.parity_word    = acc[r];
					res.row_index      = r[2:0];
					res.word_position  = col_pos[11:0];
					res.last_of_column = (r == k - 1);
					res.last_of_packet = last_p;
					parity_q.push_back(res);
				end
				foreach (acc[i]) acc[i] = '0;
				col_pos = last_p ? 0 : ((col_pos + 1) & 12'hFFF);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_item;
			if (parity_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected parity transfer %p", got);
				return;
			end
			exp_item = parity_q.pop_front();
			if (got !== exp_item) begin
				errors++;
				if (errors <= 10) $display("parity mismatch: expected %p, got %p", exp_item, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;

	parity_scoreboard sb;
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned quiet_cycles;

	cauchy_rs_parity_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in        (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out       (out_item)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_input(in_item);
			if (out_valid && !out_stall) sb.check_result(out_item);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(logic [15:0] data, logic [7:0] pidx);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{data_word: data, packet_index: pidx};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// hold input low until every parity word is out, then let the datapath settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.parity_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [12:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_mode(int unsigned n, int unsigned k, int unsigned w);
		drain();
		write_cfg(CFG_INFO_COUNT, 13'(n));
		write_cfg(CFG_REDUNDANCY_COUNT, 13'(k));
		write_cfg(CFG_WORDS_PER_PACKET, 13'(w));
	endtask

	// well-formed columns with random data, a tenth of the words random noise
	task automatic random_phase(int unsigned items);
		int unsigned n;
		int unsigned sent;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9) == 0) ? 256 : $urandom_range(1, 8);
			set_mode(n, $urandom_range(1, 8),
				($urandom_range(7) == 0) ? 4096 : $urandom_range(1, 5));
			repeat ($urandom_range(2, 5)) begin
				for (int p = 0; p < n && p < 12; p++) begin
					if ($urandom_range(9) == 0)
						send_word(16'($urandom), 8'($urandom));
					else
						send_word(16'($urandom), (n > 12 && p == 11) ? 8'(n - 1) : 8'(p));
					sent++;
				end
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear_state();
		src_idle_pct   = 24;
		sink_stall_pct = 45;
		quiet_cycles   = 0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_INFO_COUNT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_stall = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset configuration: a full column with field extremes and stray indexes
		send_word(16'h0000, 8'd0);
		send_word(16'hFFFF, 8'd1);
		send_word(16'h8001, 8'd255);
		send_word(16'h7FFE, 8'd2);
		send_word(16'h1234, 8'd4);
		send_word(16'hFFFF, 8'd3);
		// one packet per column, all eight rows, one word per packet
		set_mode(1, 8, 1);
		send_word(16'hFFFF, 8'd0);
		send_word(16'h0001, 8'd0);
		// no information packets: nothing closes
		set_mode(0, 2, 3);
		send_word(16'hA5A5, 8'd0);
		send_word(16'h5A5A, 8'd255);
		// no redundancy rows: columns close silently, then saturated row count
		set_mode(2, 0, 0);
		send_word(16'h1111, 8'd0);
		send_word(16'h2222, 8'd1);
		set_mode(2, 15, 8191);
		send_word(16'h3333, 8'd0);
		send_word(16'h4444, 8'd1);
		// widest code block, and a count beyond it that saturates
		set_mode(256, 3, 4096);
		send_word(16'hCAFE, 8'd0);
		send_word(16'hBEEF, 8'd128);
		send_word(16'hFFFF, 8'd255);
		set_mode(511, 1, 2);
		send_word(16'h00FF, 8'd17);
		send_word(16'hFF00, 8'd255);

		random_phase(50);
		src_idle_pct   = 45;
		sink_stall_pct = 24;
		random_phase(50);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		random_phase(50);

		drain();
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/crpe_pkg.sv
hw/rtl/crpe_ctrl.sv
hw/rtl/crpe_dp.sv
hw/rtl/cauchy_rs_parity_encoder.sv
test/cauchy_rs_parity_encoder_tb.sv
